[rtl/mlsq_pkg.sv]
// shared types and constants of the multilevel srtf quantum scheduler
package mlsq_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_SEL_WAIT,
		ST_PICK,
		ST_RUN,
		ST_RUN_WAIT,
		ST_RES
	} state_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [15:0] TIME_MAX      = 16'hFFFF;
	localparam logic [3:0]  QUANTUM_RESET = 4'd2;

	typedef struct packed {
		logic        operation;
		logic [3:0]  slot;
		logic [15:0] arrival_time;
		logic [15:0] work_length;
		logic [2:0]  priority_level;
	} in_req_t;

	typedef struct packed {
		logic [3:0]  running_slot;
		logic        idle;
		logic        finished;
		logic [15:0] finish_time;
		logic [15:0] turnaround;
		logic [15:0] waited;
	} out_res_t;

endpackage

[rtl/multilevel_srtf_quantum_scheduler.sv]
// top level of the multilevel srtf quantum scheduler
// A load request writes its table slot directly. A tick request walks the task table
// through its single read port: with a slice already running it makes one read-modify-write
// pass plus wrap-up, and when a new task must be selected it first adds a selection pass.
// An idle tick runs the selection pass alone. Results sit in an output register, so loads
// keep being taken while a result waits to be collected.
module multilevel_srtf_quantum_scheduler #(
	parameter int SLOTS  = 16,
	parameter int LEVELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               quantum_we,
	input  logic [3:0]         quantum_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  mlsq_pkg::in_req_t  in_req,
	output logic               out_valid,
	input  logic               out_ready,
	output mlsq_pkg::out_res_t out_res
);

	localparam int IW = $clog2(SLOTS);
	localparam int LW = $clog2(LEVELS);

	typedef struct packed {
		logic [15:0]   ready_time;
		logic [15:0]   remaining;
		logic [LW-1:0] level;
		logic [15:0]   wait_cnt;
	} entry_t;

	entry_t mem [SLOTS];
	logic [SLOTS-1:0] slot_vld_q;

	mlsq_pkg::state_t state_q, state_d;

	logic [IW-1:0] cnt_q;
	logic [3:0]    quantum_q;
	logic [15:0]   clock_q;
	logic [IW-1:0] cur_q;
	logic [LW-1:0] cur_level_q;
	logic [3:0]    ticks_q;
	logic          active_q;
	logic          res_idle_q;

	logic          best_found_q;
	logic [LW-1:0] best_level_q;
	logic [15:0]   best_rem_q;
	logic [IW-1:0] best_slot_q;
	logic          pre_found_q;
	logic [LW-1:0] pre_level_q;
	logic [15:0]   run_rem_q;
	logic [15:0]   run_ready_q;
	logic [15:0]   run_wait_q;

	logic                out_valid_q;
	mlsq_pkg::out_res_t out_q;

	logic          rd_en_s1;
	logic          pass_s1;
	logic [IW-1:0] idx_s1;
	logic          vld_bit_s1;
	entry_t        ent_s1;

	logic          rd_issue;
	logic          cnt_last;
	logic          res_fire;
	logic          in_fire;
	logic          load_fire;
	logic          tick_fire;
	logic          load_in_range;
	logic [IW-1:0] load_idx;
	logic [LW-1:0] load_level;

	logic          mem_we;
	logic [IW-1:0] mem_wa;
	entry_t        mem_wd;

	logic [15:0] clock_next;
	logic [15:0] s1_rem;
	logic [15:0] s1_wait;
	logic        s1_is_run;
	logic [15:0] s1_new_rem;
	logic [15:0] s1_new_wait;
	logic        s1_sel_ready;
	logic        s1_sel_better;
	logic        s1_pre_ready;
	logic        s1_sel_take;
	logic        s1_pre_take;

	logic [3:0]  ticks_new;
	logic [3:0]  quantum_eff;
	logic        run_finished;
	logic        slice_keep;

	// control decode
	always_comb begin
		in_ready = 1'b0;
		rd_issue = 1'b0;
		res_fire = 1'b0;
		case (state_q)
			mlsq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			mlsq_pkg::ST_SEL, mlsq_pkg::ST_RUN: begin
				rd_issue = 1'b1;
			end
			mlsq_pkg::ST_RES: begin
				res_fire = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign cnt_last  = (cnt_q == IW'(SLOTS - 1));
	assign in_fire   = in_valid && in_ready;
	assign load_fire = in_fire && (in_req.operation == mlsq_pkg::OP_LOAD);
	assign tick_fire = in_fire && (in_req.operation == mlsq_pkg::OP_TICK);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mlsq_pkg::ST_IDLE: begin
				if (tick_fire) begin
					state_d = active_q ? mlsq_pkg::ST_RUN : mlsq_pkg::ST_SEL;
				end
			end
			mlsq_pkg::ST_SEL: begin
				if (cnt_last) begin
					state_d = mlsq_pkg::ST_SEL_WAIT;
				end
			end
			mlsq_pkg::ST_SEL_WAIT: begin
				state_d = mlsq_pkg::ST_PICK;
			end
			mlsq_pkg::ST_PICK: begin
				state_d = best_found_q ? mlsq_pkg::ST_RUN : mlsq_pkg::ST_RES;
			end
			mlsq_pkg::ST_RUN: begin
				if (cnt_last) begin
					state_d = mlsq_pkg::ST_RUN_WAIT;
				end
			end
			mlsq_pkg::ST_RUN_WAIT: begin
				state_d = mlsq_pkg::ST_RES;
			end
			mlsq_pkg::ST_RES: begin
				if (res_fire) begin
					state_d = mlsq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mlsq_pkg::ST_IDLE;
			end
		endcase
	end

	// load decode
	assign load_in_range = int'(in_req.slot) < SLOTS;
	assign load_idx      = IW'(in_req.slot);
	assign load_level    = (int'(in_req.priority_level) >= LEVELS) ? LW'(LEVELS - 1)
		: LW'(in_req.priority_level);

	// per-slot evaluation of the entry read last cycle
	assign clock_next    = (clock_q == mlsq_pkg::TIME_MAX) ? clock_q : clock_q + 16'd1;
	assign s1_rem        = vld_bit_s1 ? ent_s1.remaining : 16'd0;
	assign s1_wait       = vld_bit_s1 ? ent_s1.wait_cnt : 16'd0;
	assign s1_is_run     = (idx_s1 == cur_q);
	assign s1_new_rem    = s1_is_run ? s1_rem - 16'd1 : s1_rem;
	assign s1_new_wait   = (!s1_is_run && s1_rem != 16'd0 && ent_s1.ready_time < clock_next
		&& s1_wait != mlsq_pkg::TIME_MAX) ? s1_wait + 16'd1 : s1_wait;
	assign s1_sel_ready  = (s1_rem != 16'd0) && (ent_s1.ready_time <= clock_q);
	assign s1_sel_better = !best_found_q
		|| ({ent_s1.level, s1_rem} < {best_level_q, best_rem_q});
	assign s1_pre_ready  = (s1_new_rem != 16'd0) && (ent_s1.ready_time <= clock_next);
	assign s1_sel_take   = rd_en_s1 && !pass_s1 && s1_sel_ready && s1_sel_better;
	assign s1_pre_take   = rd_en_s1 && pass_s1 && s1_pre_ready
		&& (!pre_found_q || ent_s1.level < pre_level_q);

	// table write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = load_idx;
		mem_wd.ready_time = in_req.arrival_time;
		mem_wd.remaining  = in_req.work_length;
		mem_wd.level      = load_level;
		mem_wd.wait_cnt   = 16'd0;
		if (rd_en_s1 && pass_s1) begin
			mem_we = vld_bit_s1;
			mem_wa = idx_s1;
			mem_wd.ready_time = ent_s1.ready_time;
			mem_wd.remaining  = s1_new_rem;
			mem_wd.level      = ent_s1.level;
			mem_wd.wait_cnt   = s1_new_wait;
		end else if (load_fire && load_in_range) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_issue) begin
			ent_s1 <= mem[cnt_q];
		end
	end

	// slice wrap-up
	assign ticks_new    = ticks_q + 4'd1;
	assign quantum_eff  = (quantum_q == 4'd0) ? 4'd1 : quantum_q;
	assign run_finished = (run_rem_q == 16'd0);
	assign slice_keep   = !run_finished && (ticks_new < quantum_eff)
		&& !(pre_found_q && pre_level_q < cur_level_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mlsq_pkg::ST_IDLE;
			cnt_q        <= '0;
			quantum_q    <= mlsq_pkg::QUANTUM_RESET;
			clock_q      <= '0;
			cur_q        <= '0;
			ticks_q      <= '0;
			active_q     <= 1'b0;
			res_idle_q   <= 1'b0;
			best_found_q <= 1'b0;
			pre_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			slot_vld_q   <= '0;
			rd_en_s1     <= 1'b0;
			pass_s1      <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_en_s1 <= rd_issue;
			pass_s1  <= (state_q == mlsq_pkg::ST_RUN);
			if (quantum_we) begin
				quantum_q <= quantum_wdata;
			end
			if (rd_issue) begin
				cnt_q <= cnt_last ? '0 : cnt_q + IW'(1);
			end
			if (load_fire && load_in_range) begin
				slot_vld_q[load_idx] <= 1'b1;
				if (active_q && cur_q == load_idx) begin
					active_q <= 1'b0;
					ticks_q  <= '0;
				end
			end
			if (tick_fire) begin
				best_found_q <= 1'b0;
				pre_found_q  <= 1'b0;
				res_idle_q   <= 1'b0;
			end
			if (s1_sel_take) begin
				best_found_q <= 1'b1;
			end
			if (s1_pre_take) begin
				pre_found_q <= 1'b1;
			end
			if (state_q == mlsq_pkg::ST_PICK) begin
				if (best_found_q) begin
					cur_q    <= best_slot_q;
					active_q <= 1'b1;
					ticks_q  <= '0;
				end else begin
					res_idle_q <= 1'b1;
				end
			end
			if (res_fire) begin
				clock_q <= clock_next;
				if (!res_idle_q) begin
					active_q <= slice_keep;
					ticks_q  <= slice_keep ? ticks_new : 4'd0;
				end
			end
			out_valid_q <= res_fire || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			idx_s1     <= cnt_q;
			vld_bit_s1 <= slot_vld_q[cnt_q];
		end
		if (s1_sel_take) begin
			best_level_q <= ent_s1.level;
			best_rem_q   <= s1_rem;
			best_slot_q  <= idx_s1;
		end
		if (s1_pre_take) begin
			pre_level_q <= ent_s1.level;
		end
		if (rd_en_s1 && pass_s1 && s1_is_run) begin
			run_rem_q   <= s1_new_rem;
			run_ready_q <= ent_s1.ready_time;
			run_wait_q  <= s1_wait;
		end
		if (state_q == mlsq_pkg::ST_PICK) begin
			cur_level_q <= best_level_q;
		end
		if (res_fire) begin
			out_q.finish_time <= clock_next;
			if (res_idle_q) begin
				out_q.running_slot <= 4'd0;
				out_q.idle         <= 1'b1;
				out_q.finished     <= 1'b0;
				out_q.turnaround   <= 16'd0;
				out_q.waited       <= 16'd0;
			end else begin
				out_q.running_slot <= 4'(cur_q);
				out_q.idle         <= 1'b0;
				out_q.finished     <= run_finished;
				out_q.turnaround   <= run_finished ? clock_next - run_ready_q : 16'd0;
				out_q.waited       <= run_finished ? run_wait_q : 16'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

`ifndef SYNTHESIS
	a_idle_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.idle |-> out_res.running_slot == 4'd0 && !out_res.finished)
		else $error("idle result carries a running task");

	a_clock_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> clock_q >= $past(clock_q))
		else $error("scheduler time went backward");

	a_inactive_no_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> ticks_q == 4'd0)
		else $error("slice tick count left over without an active slice");
`endif

endmodule
